// ===== rtl/sdvl_pkg.sv =====
// Shared types and codes for the sorted descending value list.
// No dependencies; the top module and the engine refer to it by scoped names.
package sdvl_pkg;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_DELETE = 1'b1
	} kind_t;

	// Finished request handed from the engine to the output register.
	typedef struct packed {
		logic               valid;
		status_t            status;
		logic signed [31:0] top_value;
	} done_t;

endpackage

// ===== rtl/sdvl_if.sv =====
// Request and response channel interfaces of the sorted descending value list.
// Depends on nothing; payloads are plain logic vectors.
interface sdvl_req_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [31:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

interface sdvl_rsp_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic        [4:0]  count;
	logic signed [31:0] top_value;
	logic               top_valid;

	modport source (output valid, output status, output count, output top_value,
		output top_valid, input ready);
	modport sink   (input valid, input status, input count, input top_value,
		input top_valid, output ready);
endinterface

// ===== rtl/sorted_descending_value_list.sv =====
// Sorted descending value list: holds up to DEPTH signed 32-bit values,
// largest first, and answers insert and delete requests.
//
// Channels: req (kind, value) in, rsp (status, count, top_value, top_valid)
// out, both valid/ready; a request moves when valid and ready are high.
// Insert places the value ahead of every stored value not greater than it;
// delete removes the first entry equal to value. Each request gives one
// response. A full insert, an empty delete or a missed delete changes nothing.
//
// Timing: one shared compare unit walks the value memory one entry a cycle,
// and req.ready is low while a request is worked on. An insert walks up from
// the lowest stored entry until it finds its place, a delete walks every
// stored entry, and a rejected request goes straight to its response. The next
// request is accepted the cycle after the response is loaded, so a response
// waiting in the output register does not block new work; only a second
// finished request waits for it to drain.
//
// Reset clears the count and control; the memory is not cleared and needs no
// pass. While rsp.ready is low the response holds steady.
module sorted_descending_value_list #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	sdvl_req_if.sink    req,
	sdvl_rsp_if.source  rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	sdvl_pkg::done_t     done;
	logic [CW-1:0]       eng_count;
	logic                eng_idle;
	logic                load;

	logic                out_valid_q;
	logic [1:0]          out_status_q;
	logic [4:0]          out_count_q;
	logic signed [31:0]  out_top_q;
	logic                out_top_valid_q;
	logic [31:0]         count_ext;

	assign req.ready = eng_idle;
	assign load      = done.valid && (!out_valid_q || rsp.ready);
	assign count_ext = 32'(eng_count);

	sdvl_engine #(
		.DEPTH(DEPTH)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.start (req.valid && req.ready),
		.kind  (req.kind),
		.value (req.value),
		.idle  (eng_idle),
		.ack   (load),
		.done  (done),
		.count (eng_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q    <= done.status;
			out_count_q     <= count_ext[4:0];
			out_top_valid_q <= eng_count != '0;
			out_top_q       <= (eng_count != '0) ? done.top_value : 32'sd0;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.count     = out_count_q;
	assign rsp.top_value = out_top_q;
	assign rsp.top_valid = out_top_valid_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		eng_count <= CW'(DEPTH))
		else $error("stored count above capacity");

	a_full_only_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done.valid && done.status == sdvl_pkg::ST_FULL |-> eng_count == CW'(DEPTH))
		else $error("full status with free space");

	a_empty_only_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done.valid && done.status == sdvl_pkg::ST_EMPTY |-> eng_count == '0)
		else $error("empty status with stored values");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while engine busy");
`endif

endmodule

// ===== rtl/sdvl_engine.sv =====
// Storage and sequencer of the sorted descending value list: value memory,
// one shared compare unit and the insert/delete walk. Uses sdvl_pkg.
module sdvl_engine #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               kind,
	input  logic signed [31:0] value,
	output logic               idle,
	input  logic               ack,
	output sdvl_pkg::done_t    done,
	output logic [CW-1:0]      count
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_PLACE,
		S_DEL,
		S_DONE
	} state_t;

	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	state_t              state_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       count_q;
	logic                found_q;
	logic signed [31:0]  val_q;
	logic signed [31:0]  top_q;
	sdvl_pkg::status_t   status_q;

	logic signed [31:0]  mem [DEPTH];
	logic signed [31:0]  rdata_q;

	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic signed [31:0]  wr_data;

	logic [CW-1:0]       idx_dn;
	logic [CW-1:0]       idx_up;
	logic [CW-1:0]       cnt_dn;
	logic                greater;
	logic                equal;

	// The one compare unit: stored entry against the request value.
	assign greater = rdata_q > val_q;
	assign equal   = rdata_q == val_q;
	assign idx_dn  = idx_q - 1'b1;
	assign idx_up  = idx_q + 1'b1;
	assign cnt_dn  = count_q - 1'b1;

	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rdata_q;
		case (state_q)
			S_IDLE: begin
				// prime the read: head entry for a delete, lowest entry for an insert
				if (kind == sdvl_pkg::KIND_DELETE) begin
					rd_addr = '0;
				end else begin
					rd_addr = cnt_dn[AW-1:0];
				end
			end
			S_INS: begin
				// move the entry up one place, or drop the value in above it
				rd_addr = idx_dn[AW-1:0];
				wr_en   = 1'b1;
				wr_addr = idx_up[AW-1:0];
				wr_data = greater ? val_q : rdata_q;
			end
			S_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = val_q;
			end
			S_DEL: begin
				// past the match, close the gap one entry at a time
				rd_addr = idx_up[AW-1:0];
				wr_en   = found_q;
				wr_addr = idx_dn[AW-1:0];
				wr_data = rdata_q;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			count_q  <= '0;
			found_q  <= 1'b0;
			val_q    <= '0;
			top_q    <= '0;
			status_q <= sdvl_pkg::ST_OK;
		end else begin
			// keep a copy of the head entry for the response
			if (wr_en && wr_addr == '0) begin
				top_q <= wr_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						val_q    <= value;
						status_q <= sdvl_pkg::ST_OK;
						if (kind == sdvl_pkg::KIND_INSERT) begin
							if (count_q == FULL_CNT) begin
								status_q <= sdvl_pkg::ST_FULL;
								state_q  <= S_DONE;
							end else if (count_q == '0) begin
								state_q <= S_PLACE;
							end else begin
								idx_q   <= cnt_dn;
								state_q <= S_INS;
							end
						end else begin
							if (count_q == '0) begin
								status_q <= sdvl_pkg::ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								idx_q   <= '0;
								found_q <= 1'b0;
								state_q <= S_DEL;
							end
						end
					end
				end
				S_INS: begin
					if (greater) begin
						count_q <= count_q + 1'b1;
						state_q <= S_DONE;
					end else if (idx_q == '0) begin
						state_q <= S_PLACE;
					end else begin
						idx_q <= idx_dn;
					end
				end
				S_PLACE: begin
					count_q <= count_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DEL: begin
					if (!found_q && equal) begin
						found_q <= 1'b1;
					end
					if (idx_q == cnt_dn) begin
						if (found_q || equal) begin
							count_q <= cnt_dn;
						end else begin
							status_q <= sdvl_pkg::ST_NOT_FOUND;
						end
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_up;
					end
				end
				S_DONE: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle           = state_q == S_IDLE;
	assign done.valid     = state_q == S_DONE;
	assign done.status    = status_q;
	assign done.top_value = top_q;
	assign count          = count_q;

endmodule
